// ===== hw/rtl/cbq_pkg.sv =====
// Shared constants, types and codes for the cascaded biquad filter.
package cbq_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 32;
  localparam int NUM_SECTIONS = 2;
  localparam int NUM_TAPS     = 5;
  localparam int FRAC_SHIFT   = COEF_BITS - 2;
  localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS     = PROD_BITS + 3;
  localparam int RND_BITS     = ACC_BITS - FRAC_SHIFT;
  localparam int TAP_BITS     = 3;
  localparam int SEC_BITS     = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic signed [RND_BITS-1:0]    rnd_t;
  typedef logic [TAP_BITS-1:0]           tap_t;
  typedef logic [SEC_BITS-1:0]           sec_t;

  // tap order matches the register index order
  localparam tap_t TAP_B0    = 3'd0;
  localparam tap_t TAP_B1    = 3'd1;
  localparam tap_t TAP_B2    = 3'd2;
  localparam tap_t TAP_A1    = 3'd3;
  localparam tap_t TAP_A2    = 3'd4;
  localparam tap_t TAP_DRAIN = 3'd5;

  localparam acc_t RND_HALF = acc_t'(64'd1 << (FRAC_SHIFT - 1));
  localparam rnd_t SAT_MAX  = rnd_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam rnd_t SAT_MIN  = rnd_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic sub;
  } mac_ctl_t;

endpackage

// ===== hw/rtl/cbq_mac.sv =====
// Shared multiply-accumulate unit with round-to-nearest and saturation.
module cbq_mac import cbq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  coef_t    coef,
  input  sample_t  operand,
  output sample_t  y_sat
);

  prod_t prod_r;
  logic  prod_vld_r;
  logic  sub_r;
  acc_t  acc_r;
  acc_t  acc_nxt;
  acc_t  prod_ext;
  acc_t  rnd_sum;
  rnd_t  rnd_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r <= prod_t'(coef) * prod_t'(operand);
      sub_r  <= ctl.sub;
    end
  end

  assign prod_ext = acc_t'(prod_r);
  assign acc_nxt  = sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign rnd_sum = acc_r + RND_HALF;
  assign rnd_val = rnd_t'(rnd_sum[ACC_BITS-1:FRAC_SHIFT]);

  always_comb begin
    if (rnd_val > SAT_MAX) begin
      y_sat = sample_t'(SAT_MAX);
    end else if (rnd_val < SAT_MIN) begin
      y_sat = sample_t'(SAT_MIN);
    end else begin
      y_sat = sample_t'(rnd_val);
    end
  end

endmodule

// ===== hw/rtl/cascaded_biquad_lr4_filter.sv =====
// Top level of the cascaded biquad (Linkwitz-Riley) filter.
// Each accepted sample runs through NUM_SECTIONS direct-form-I biquads that share
// one set of five Q2.30 coefficients, written through the cfg port (index 0..4:
// b0, b1, b2, a1, a2; other indexes are ignored). A single 32x24 multiplier with
// a 59-bit accumulator does all products: each section runs five products, one
// drain and one round/saturate step, and the last round waits until the output
// register is free. in_ready is high only while the sequencer is idle; the
// result sits in an output register until taken.
module cascaded_biquad_lr4_filter import cbq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample_in,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t out_sample_out,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  tap_t    cfg_index,
  input  coef_t   cfg_data
);

  state_t   state_r;
  state_t   state_nxt;
  tap_t     tap_r;
  sec_t     sec_r;
  sample_t  x_r;
  coef_t    coef_r [NUM_TAPS];
  sample_t  xh_r   [NUM_SECTIONS][2];
  sample_t  yh_r   [NUM_SECTIONS][2];
  logic     out_valid_r;
  sample_t  out_sample_r;

  mac_ctl_t mac_ctl;
  coef_t    mac_coef;
  sample_t  mac_operand;
  sample_t  y_sat;
  logic     last_sec;
  logic     out_free;
  logic     step_done;
  logic     out_load;

  cbq_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .coef    (mac_coef),
    .operand (mac_operand),
    .y_sat   (y_sat)
  );

  assign last_sec  = (sec_r == sec_t'(NUM_SECTIONS - 1));
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_sample_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (tap_r == TAP_DRAIN) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (!last_sec) begin
          state_nxt = ST_RUN;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    mac_ctl.issue = (state_r == ST_RUN) && (tap_r != TAP_DRAIN);
    mac_ctl.start = (state_r == ST_RUN) && (tap_r == TAP_B0);
    mac_ctl.sub   = (tap_r == TAP_A1) || (tap_r == TAP_A2);
    step_done     = (state_r == ST_ROUND) && (!last_sec || out_free);
    out_load      = (state_r == ST_ROUND) && last_sec && out_free;
  end

  always_comb begin
    case (tap_r)
      TAP_B0: begin
        mac_coef    = coef_r[TAP_B0];
        mac_operand = x_r;
      end
      TAP_B1: begin
        mac_coef    = coef_r[TAP_B1];
        mac_operand = xh_r[sec_r][0];
      end
      TAP_B2: begin
        mac_coef    = coef_r[TAP_B2];
        mac_operand = xh_r[sec_r][1];
      end
      TAP_A1: begin
        mac_coef    = coef_r[TAP_A1];
        mac_operand = yh_r[sec_r][0];
      end
      TAP_A2: begin
        mac_coef    = coef_r[TAP_A2];
        mac_operand = yh_r[sec_r][1];
      end
      default: begin
        mac_coef    = '0;
        mac_operand = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= TAP_B0;
      sec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RUN) begin
        tap_r <= tap_r + tap_t'(1);
      end else begin
        tap_r <= TAP_B0;
      end
      if (state_r == ST_IDLE) begin
        sec_r <= '0;
      end else if (step_done && !last_sec) begin
        sec_r <= sec_r + sec_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r <= in_sample_in;
    end else if (step_done) begin
      x_r <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SECTIONS; s++) begin
        xh_r[s][0] <= '0;
        xh_r[s][1] <= '0;
        yh_r[s][0] <= '0;
        yh_r[s][1] <= '0;
      end
    end else if (step_done) begin
      xh_r[sec_r][1] <= xh_r[sec_r][0];
      xh_r[sec_r][0] <= x_r;
      yh_r[sec_r][1] <= yh_r[sec_r][0];
      yh_r[sec_r][0] <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index <= TAP_A2)) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= y_sat;
    end
  end

endmodule
